// ===== sv/mbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbs_pkg
// Shared types and constants of the maze backtracker step block.
// ----------------------------------------------------------------------------
package mbs_pkg;

    localparam int MAX_SIDE_DEF = 64;

    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_DATA_W-1:0] SIDE_RESET = 7'd8;

    localparam logic CMD_RESTART = 1'b0;
    localparam logic CMD_STEP    = 1'b1;

    localparam int RND_W      = 16;
    localparam int CELL_W     = 12;
    localparam int COORD_OUT_W = 6;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_PAD_W  = 2;
    localparam int OUT_USER_W = 2;

    localparam logic [1:0] DIR_RIGHT = 2'd0;
    localparam logic [1:0] DIR_UP    = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    // floor(r / 3) = (r * DIV3_MUL) >> DIV3_SHIFT, exact for 16-bit r
    localparam logic [15:0] DIV3_MUL   = 16'd43691;
    localparam int          DIV3_SHIFT = 17;

    // visited map tag; a restart moves to the next epoch
    localparam int EPOCH_W = 6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RESTART,
        ST_FINISH,
        ST_NB23,
        ST_DECIDE,
        ST_POPRD
    } state_t;

endpackage

// ===== sv/maze_backtracker_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maze_backtracker_step
// Randomized depth-first maze carver with visited map and path stack in RAM.
// ----------------------------------------------------------------------------
// One word in gives one word out. A carving step passes through NB23 and DECIDE,
// a step on an empty stack through FINISH: the visited map has two read ports,
// so the four neighbor tags are fetched in two reads, and a pop that leaves
// entries passes through POPRD as well to load the new stack top. A restart
// passes through RESTART, except that the first restart after reset and every
// (2**EPOCH_W - 1)th restart after it run a clearing pass over the visited map
// first, one entry per cycle over all MAX_SIDE*MAX_SIDE entries (4096 at the
// default); no input word is taken during the pass. Width and height must be
// written by the user only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module maze_backtracker_step #(
    parameter int MAX_SIDE = mbs_pkg::MAX_SIDE_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [mbs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mbs_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mbs_pkg::IN_DATA_W-1:0]       s_tdata,   // random_value
    input  logic                                s_tuser,   // cmd
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // from_cell, to_cell, to_x, to_y, direction, zero pad
    output logic [mbs_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic [mbs_pkg::OUT_USER_W-1:0]      m_tuser    // edge_valid, finished
);

    localparam int CW    = $clog2(MAX_SIDE);
    localparam int SW    = (CW + 1 > mbs_pkg::CFG_DATA_W) ? CW + 1 : mbs_pkg::CFG_DATA_W;
    localparam int SLOTS = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(SLOTS);
    localparam int DW    = $clog2(SLOTS + 1);
    localparam int FW    = CW + SW + 1;
    localparam int EW    = mbs_pkg::EPOCH_W;
    localparam logic [EW-1:0] EPOCH_MAX = {EW{1'b1}};

    mbs_pkg::state_t state_reg, state_next;

    logic [mbs_pkg::CFG_DATA_W-1:0] width_reg, height_reg;
    logic [SW-1:0]                  w_cl, h_cl, w_ext, h_ext;

    logic                           cmd_reg, cmd_next;
    logic [mbs_pkg::RND_W-1:0]      rnd_reg, rnd_next;
    logic [mbs_pkg::RND_W-1:0]      q3_reg, q3_next;
    logic [mbs_pkg::RND_W-1:0]      prod3;
    logic [31:0]                    div_prod;
    logic [1:0]                     rem3_reg, rem3_next;
    logic [mbs_pkg::CELL_W-1:0]     from_reg, from_next;
    logic                           fr_reg, fr_next, fu_reg, fu_next;
    logic [EW-1:0]                  epoch_reg, epoch_next;
    logic [AW-1:0]                  clr_reg, clr_next;
    logic [DW-1:0]                  depth_reg, depth_next;
    logic [2*CW-1:0]                top_reg, top_next;

    logic [CW-1:0]                  top_x, top_y;
    logic                           right_ok, up_ok, left_ok, down_ok;
    logic                           depth_zero, clr_last, out_free;
    logic [FW-1:0]                  from_sum;

    // visited map: epoch tag per slot
    logic [EW-1:0]                  vis_mem [SLOTS];
    logic                           vis_we, vis_re;
    logic [AW-1:0]                  vis_waddr, vis_raddr_a, vis_raddr_b;
    logic [EW-1:0]                  vis_wdata, vis_qa, vis_qb;

    // path stack: {y, x} per entry
    logic [2*CW-1:0]                stk_mem [SLOTS];
    logic                           stk_we, stk_re;
    logic [AW-1:0]                  stk_waddr, stk_raddr;
    logic [2*CW-1:0]                stk_wdata, stk_q;

    // choice of neighbor
    logic [3:0]                     free_vec;
    logic [2:0]                     free_cnt, seen;
    logic [1:0]                     pick, dir_sel;
    logic                           found;
    logic [CW-1:0]                  nx, ny;
    logic [mbs_pkg::CELL_W-1:0]     to_cell, w12;

    // output register
    logic                           m_valid_reg, m_valid_next;
    logic [mbs_pkg::OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic [mbs_pkg::OUT_USER_W-1:0] m_user_reg, m_user_next;
    logic                           out_load;
    logic                           ov_edge, ov_fin;
    logic [mbs_pkg::CELL_W-1:0]     ov_from, ov_to;
    logic [mbs_pkg::COORD_OUT_W-1:0] ov_tx, ov_ty;
    logic [1:0]                     ov_dir;

    assign w_ext = SW'(width_reg);
    assign h_ext = SW'(height_reg);
    assign w_cl  = (w_ext == '0) ? SW'(1) : ((w_ext > SW'(MAX_SIDE)) ? SW'(MAX_SIDE) : w_ext);
    assign h_cl  = (h_ext == '0) ? SW'(1) : ((h_ext > SW'(MAX_SIDE)) ? SW'(MAX_SIDE) : h_ext);

    assign top_x    = top_reg[CW-1:0];
    assign top_y    = top_reg[2*CW-1:CW];
    assign right_ok = (SW'(top_x) + SW'(1)) < w_cl;
    assign down_ok  = (SW'(top_y) + SW'(1)) < h_cl;
    assign up_ok    = (top_y != '0);
    assign left_ok  = (top_x != '0);

    assign depth_zero = (depth_reg == '0) || (depth_reg > DW'(SLOTS));
    assign clr_last   = (clr_reg == AW'(SLOTS - 1));
    assign out_free   = !m_valid_reg || m_tready;
    assign from_sum   = FW'(top_y) * FW'(w_cl) + FW'(top_x);
    assign div_prod   = 32'(s_tdata) * 32'(mbs_pkg::DIV3_MUL);
    assign prod3      = q3_reg + (q3_reg << 1);
    assign w12        = mbs_pkg::CELL_W'(w_cl);

    assign s_tready = (state_reg == mbs_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // neighbor choice from free flags of right, up, left, down
    always_comb
    begin
        free_vec = {down_ok && (vis_qb != epoch_reg), left_ok && (vis_qa != epoch_reg),
                    fu_reg, fr_reg};
        free_cnt = 3'(free_vec[0]) + 3'(free_vec[1]) + 3'(free_vec[2]) + 3'(free_vec[3]);
        case (free_cnt)
            3'd2:    pick = {1'b0, rnd_reg[0]};
            3'd3:    pick = rem3_reg;
            3'd4:    pick = rnd_reg[1:0];
            default: pick = 2'd0;
        endcase
        seen    = '0;
        found   = 1'b0;
        dir_sel = mbs_pkg::DIR_RIGHT;
        for (int i = 0; i < 4; i++)
        begin
            if (free_vec[i])
            begin
                if (!found && (seen[1:0] == pick))
                begin
                    dir_sel = 2'(i);
                    found   = 1'b1;
                end
                seen = seen + 3'd1;
            end
        end
        nx      = top_x;
        ny      = top_y;
        to_cell = from_reg;
        case (dir_sel)
            mbs_pkg::DIR_RIGHT:
            begin
                nx      = top_x + CW'(1);
                to_cell = from_reg + mbs_pkg::CELL_W'(1);
            end
            mbs_pkg::DIR_UP:
            begin
                ny      = top_y - CW'(1);
                to_cell = from_reg - w12;
            end
            mbs_pkg::DIR_LEFT:
            begin
                nx      = top_x - CW'(1);
                to_cell = from_reg - mbs_pkg::CELL_W'(1);
            end
            default:
            begin
                ny      = top_y + CW'(1);
                to_cell = from_reg + w12;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mbs_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == mbs_pkg::CMD_RESTART)
                        state_next = (epoch_reg == EPOCH_MAX) ? mbs_pkg::ST_CLEAR
                                                              : mbs_pkg::ST_RESTART;
                    else
                        state_next = depth_zero ? mbs_pkg::ST_FINISH : mbs_pkg::ST_NB23;
                end
            end
            mbs_pkg::ST_CLEAR:
            begin
                if (clr_last)
                    state_next = mbs_pkg::ST_RESTART;
            end
            mbs_pkg::ST_RESTART, mbs_pkg::ST_FINISH:
            begin
                if (out_free)
                    state_next = mbs_pkg::ST_IDLE;
            end
            mbs_pkg::ST_NB23:
                state_next = mbs_pkg::ST_DECIDE;
            mbs_pkg::ST_DECIDE:
            begin
                if (out_free)
                    state_next = ((free_cnt == '0) && (depth_reg > DW'(1)))
                                 ? mbs_pkg::ST_POPRD : mbs_pkg::ST_IDLE;
            end
            mbs_pkg::ST_POPRD:
                state_next = mbs_pkg::ST_IDLE;
            default:
                state_next = mbs_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cmd_next    = cmd_reg;
        rnd_next    = rnd_reg;
        q3_next     = q3_reg;
        rem3_next   = rem3_reg;
        from_next   = from_reg;
        fr_next     = fr_reg;
        fu_next     = fu_reg;
        epoch_next  = epoch_reg;
        clr_next    = clr_reg;
        depth_next  = depth_reg;
        top_next    = top_reg;
        vis_we      = 1'b0;
        vis_waddr   = '0;
        vis_wdata   = '0;
        vis_re      = 1'b0;
        vis_raddr_a = AW'(int'(top_y) * MAX_SIDE + int'(top_x) + 1);
        vis_raddr_b = AW'((int'(top_y) - 1) * MAX_SIDE + int'(top_x));
        stk_we      = 1'b0;
        stk_waddr   = AW'(depth_reg);
        stk_wdata   = {ny, nx};
        stk_re      = 1'b0;
        stk_raddr   = AW'(depth_reg - DW'(2));
        out_load    = 1'b0;
        ov_edge     = 1'b0;
        ov_fin      = 1'b0;
        ov_from     = '0;
        ov_to       = '0;
        ov_tx       = '0;
        ov_ty       = '0;
        ov_dir      = '0;
        case (state_reg)
            mbs_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next  = s_tuser;
                    rnd_next  = s_tdata;
                    q3_next   = 16'(div_prod >> mbs_pkg::DIV3_SHIFT);
                    from_next = mbs_pkg::CELL_W'(from_sum);
                    vis_re    = 1'b1;
                    if (s_tuser == mbs_pkg::CMD_RESTART)
                    begin
                        if (epoch_reg == EPOCH_MAX)
                            clr_next = '0;
                        else
                            epoch_next = epoch_reg + EW'(1);
                    end
                end
            end
            mbs_pkg::ST_CLEAR:
            begin
                vis_we    = 1'b1;
                vis_waddr = clr_reg;
                vis_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_last)
                    epoch_next = EW'(1);
            end
            mbs_pkg::ST_RESTART:
            begin
                if (out_free)
                begin
                    vis_we     = 1'b1;
                    vis_waddr  = '0;
                    vis_wdata  = epoch_reg;
                    stk_we     = 1'b1;
                    stk_waddr  = '0;
                    stk_wdata  = '0;
                    depth_next = DW'(1);
                    top_next   = '0;
                    out_load   = 1'b1;
                end
            end
            mbs_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    depth_next = '0;
                    out_load   = 1'b1;
                    ov_fin     = 1'b1;
                end
            end
            mbs_pkg::ST_NB23:
            begin
                fr_next     = right_ok && (vis_qa != epoch_reg);
                fu_next     = up_ok && (vis_qb != epoch_reg);
                rem3_next   = 2'(rnd_reg - prod3);
                vis_re      = 1'b1;
                vis_raddr_a = AW'(int'(top_y) * MAX_SIDE + int'(top_x) - 1);
                vis_raddr_b = AW'((int'(top_y) + 1) * MAX_SIDE + int'(top_x));
            end
            mbs_pkg::ST_DECIDE:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    ov_from  = from_reg;
                    if (free_cnt == '0)
                    begin
                        depth_next = depth_reg - DW'(1);
                        stk_re     = (depth_reg > DW'(1));
                    end
                    else
                    begin
                        if (depth_reg < DW'(SLOTS))
                        begin
                            stk_we     = 1'b1;
                            depth_next = depth_reg + DW'(1);
                        end
                        top_next  = {ny, nx};
                        vis_we    = 1'b1;
                        vis_waddr = AW'(int'(ny) * MAX_SIDE + int'(nx));
                        vis_wdata = epoch_reg;
                        ov_edge   = 1'b1;
                        ov_to     = to_cell;
                        ov_tx     = mbs_pkg::COORD_OUT_W'(nx);
                        ov_ty     = mbs_pkg::COORD_OUT_W'(ny);
                        ov_dir    = dir_sel;
                    end
                end
            end
            mbs_pkg::ST_POPRD:
                top_next = stk_q;
            default:
            begin
            end
        endcase
        m_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
        m_data_next  = out_load ? {{mbs_pkg::OUT_PAD_W{1'b0}}, ov_dir, ov_ty, ov_tx, ov_to,
                                   ov_from}
                                : m_data_reg;
        m_user_next  = out_load ? {ov_fin, ov_edge} : m_user_reg;
    end

    always_ff @(posedge clk)
    begin
        if (vis_we)
            vis_mem[vis_waddr] <= vis_wdata;
        if (vis_re)
        begin
            vis_qa <= vis_mem[vis_raddr_a];
            vis_qb <= vis_mem[vis_raddr_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_waddr] <= stk_wdata;
        if (stk_re)
            stk_q <= stk_mem[stk_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mbs_pkg::ST_IDLE;
            width_reg   <= mbs_pkg::SIDE_RESET;
            height_reg  <= mbs_pkg::SIDE_RESET;
            epoch_reg   <= EPOCH_MAX;
            clr_reg     <= '0;
            depth_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            epoch_reg   <= epoch_next;
            clr_reg     <= clr_next;
            depth_reg   <= depth_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en && (cfg_index == mbs_pkg::REG_WIDTH))
                width_reg <= cfg_data;
            if (cfg_wr_en && (cfg_index == mbs_pkg::REG_HEIGHT))
                height_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        rnd_reg    <= rnd_next;
        q3_reg     <= q3_next;
        rem3_reg   <= rem3_next;
        from_reg   <= from_next;
        fr_reg     <= fr_next;
        fu_reg     <= fu_next;
        top_reg    <= top_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mbs_pkg::ST_DECIDE && out_free && free_cnt != '0
         && depth_reg < DW'(SLOTS))
        |=> depth_reg == $past(depth_reg) + DW'(1))
        else $error("push did not grow the stack");

    a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mbs_pkg::ST_DECIDE || state_reg == mbs_pkg::ST_RESTART)
        |-> epoch_reg != '0)
        else $error("visited tag equals the cleared value");

    a_restart_top: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mbs_pkg::ST_RESTART && out_free)
        |=> depth_reg == DW'(1) && top_reg == '0 && cmd_reg == mbs_pkg::CMD_RESTART)
        else $error("restart left a wrong stack");

    a_finish_word: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_user_reg[1]) |-> !m_user_reg[0] && m_data_reg == '0)
        else $error("finished word carries edge data");

endmodule
